// ----- hdl/dosp_pkg.sv -----
// Shared types and constants for the DHCP option summary parser.
package dosp_pkg;

   localparam int POS_W = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] OPTIONS_START = 16'd240;
   localparam logic [POS_W-1:0] CIADDR_START  = 16'd12;
   localparam logic [POS_W-1:0] YIADDR_START  = 16'd16;
   localparam logic [POS_W-1:0] YIADDR_END    = 16'd20;
   localparam logic [POS_W-1:0] MAC_START     = 16'd28;
   localparam logic [POS_W-1:0] MAC_END       = 16'd34;
   localparam logic [POS_W-1:0] COOKIE_START  = 16'd236;

   localparam logic [31:0] COOKIE_VALUE = 32'h6382_5363;

   localparam logic [7:0] OPT_PAD      = 8'd0;
   localparam logic [7:0] OPT_END      = 8'd255;
   localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
   localparam logic [7:0] OPT_REQ_IP   = 8'd50;
   localparam logic [7:0] LEN_MSG_TYPE = 8'd1;
   localparam logic [7:0] LEN_REQ_IP   = 8'd4;

   localparam logic [1:0] PHASE_CODE = 2'd0;
   localparam logic [1:0] PHASE_LEN  = 2'd1;
   localparam logic [1:0] PHASE_DATA = 2'd2;

   localparam logic [1:0] ADDR_NONE      = 2'd0;
   localparam logic [1:0] ADDR_REQUESTED = 2'd1;
   localparam logic [1:0] ADDR_CLIENT    = 2'd2;
   localparam logic [1:0] ADDR_OFFERED   = 2'd3;

   // Where in the payload a byte falls.
   localparam logic [2:0] REGION_NONE   = 3'd0;
   localparam logic [2:0] REGION_OP     = 3'd1;
   localparam logic [2:0] REGION_CIADDR = 3'd2;
   localparam logic [2:0] REGION_YIADDR = 3'd3;
   localparam logic [2:0] REGION_MAC    = 3'd4;
   localparam logic [2:0] REGION_COOKIE = 3'd5;
   localparam logic [2:0] REGION_OPTION = 3'd6;

   typedef struct packed {
      logic [7:0]       byte_val;
      logic [2:0]       region;
      logic [POS_W-1:0] left_m1;   // bytes after this one up to the length
      logic             last;
      logic             long_enough;
   } item_type;

endpackage

// ----- hdl/dosp_front.sv -----
// Front end: counts byte positions and classifies each accepted byte.
module dosp_front
   import dosp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_payload_byte,
   input  logic [15:0]      req_payload_length,
   input  logic             req_last_byte,
   input  logic             q_full,
   output logic             q_push,
   output item_type         q_item
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] pos_next;
   logic             in_range;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign in_range  = pos_ff < req_payload_length;
   assign pos_next  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;

   always_comb begin
      q_item          = '0;
      q_item.byte_val = req_payload_byte;
      q_item.last     = req_last_byte;
      q_item.left_m1  = req_payload_length - pos_ff - 1'b1;
      q_item.long_enough = (pos_next >= OPTIONS_START) &&
                           (req_payload_length >= OPTIONS_START);
      if (!in_range) begin
         q_item.region = REGION_NONE;
      end else if (pos_ff == '0) begin
         q_item.region = REGION_OP;
      end else if (pos_ff >= CIADDR_START && pos_ff < YIADDR_START) begin
         q_item.region = REGION_CIADDR;
      end else if (pos_ff >= YIADDR_START && pos_ff < YIADDR_END) begin
         q_item.region = REGION_YIADDR;
      end else if (pos_ff >= MAC_START && pos_ff < MAC_END) begin
         q_item.region = REGION_MAC;
      end else if (pos_ff >= COOKIE_START && pos_ff < OPTIONS_START) begin
         q_item.region = REGION_COOKIE;
      end else if (pos_ff >= OPTIONS_START) begin
         q_item.region = REGION_OPTION;
      end else begin
         q_item.region = REGION_NONE;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         pos_in = req_last_byte ? '0 : pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- hdl/dosp_queue.sv -----
// Short queue of classified bytes between the front and back ends.
module dosp_queue
   import dosp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   item_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   assign full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/dosp_back.sv -----
// Back end: header capture, option walk and the summary output register.
module dosp_back
   import dosp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_summary_valid,
   output logic        rsp_is_dhcp,
   output logic [7:0]  rsp_op_code,
   output logic        rsp_type_found,
   output logic [7:0]  rsp_message_type,
   output logic [47:0] rsp_client_mac,
   output logic [1:0]  rsp_addr_kind,
   output logic [31:0] rsp_shown_address
);

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic        stopped_ff, stopped_in;
   logic [31:0] cookie_ff, cookie_in;
   logic [7:0]  op_ff, op_in;
   logic [47:0] mac_ff, mac_in;
   logic [31:0] ciaddr_ff, ciaddr_in;
   logic [31:0] yiaddr_ff, yiaddr_in;
   logic [8:0]  type_ff, type_in;
   logic [32:0] req_ip_ff, req_ip_in;
   logic [31:0] shift_ff, shift_in;

   logic        out_valid_ff, out_valid_in;
   logic        sum_valid_ff, sum_valid_in;
   logic        dhcp_ff, dhcp_in;
   logic [7:0]  op_out_ff, op_out_in;
   logic        type_found_ff, type_found_in;
   logic [7:0]  msg_type_ff, msg_type_in;
   logic [47:0] mac_out_ff, mac_out_in;
   logic [1:0]  addr_kind_ff, addr_kind_in;
   logic [31:0] addr_ff, addr_in;

   logic [7:0]  b;
   logic [7:0]  left_dec;
   logic        emit;
   logic        keep_code;

   // A byte with no result always drains; a last byte needs a free output slot.
   assign q_pop = q_valid && (!q_item.last || !out_valid_ff || rsp_ready);
   assign emit  = q_pop && q_item.last;
   assign b     = q_item.byte_val;

   assign left_dec  = bytes_left_ff - 1'b1;
   assign keep_code = (code_ff == OPT_MSG_TYPE && b == LEN_MSG_TYPE) ||
                      (code_ff == OPT_REQ_IP && b == LEN_REQ_IP);

   // Per-byte state update.
   always_comb begin
      phase_in      = phase_ff;
      code_in       = code_ff;
      bytes_left_in = bytes_left_ff;
      stopped_in    = stopped_ff;
      cookie_in     = cookie_ff;
      op_in         = op_ff;
      mac_in        = mac_ff;
      ciaddr_in     = ciaddr_ff;
      yiaddr_in     = yiaddr_ff;
      type_in       = type_ff;
      req_ip_in     = req_ip_ff;
      shift_in      = shift_ff;
      if (q_pop) begin
         unique case (q_item.region)
            REGION_OP:     op_in     = b;
            REGION_CIADDR: ciaddr_in = {ciaddr_ff[23:0], b};
            REGION_YIADDR: yiaddr_in = {yiaddr_ff[23:0], b};
            REGION_MAC:    mac_in    = {mac_ff[39:0], b};
            REGION_COOKIE: cookie_in = {cookie_ff[23:0], b};
            REGION_OPTION: begin
               if (!stopped_ff) begin
                  unique case (phase_ff)
                     PHASE_LEN: begin
                        if (q_item.left_m1 < {8'd0, b}) begin
                           stopped_in = 1'b1;
                        end else begin
                           if (!keep_code) begin
                              code_in = '0;
                           end
                           if (b == 8'd0) begin
                              phase_in = PHASE_CODE;
                           end else begin
                              bytes_left_in = b;
                              shift_in      = '0;
                              phase_in      = PHASE_DATA;
                           end
                        end
                     end
                     PHASE_DATA: begin
                        shift_in      = {shift_ff[23:0], b};
                        bytes_left_in = left_dec;
                        if (left_dec == 8'd0) begin
                           if (code_ff == OPT_MSG_TYPE) begin
                              type_in = {1'b1, b};
                           end else if (code_ff == OPT_REQ_IP) begin
                              req_ip_in = {1'b1, shift_ff[23:0], b};
                           end
                           phase_in = PHASE_CODE;
                        end
                     end
                     default: begin
                        phase_in = PHASE_CODE;
                        if (q_item.left_m1 <= 16'd1 || b == OPT_END) begin
                           stopped_in = 1'b1;
                        end else if (b != OPT_PAD) begin
                           code_in  = b;
                           phase_in = PHASE_LEN;
                        end
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // Summary of the packet, taken from the state after its last byte.
   always_comb begin
      sum_valid_in  = 1'b0;
      dhcp_in       = 1'b0;
      op_out_in     = '0;
      type_found_in = 1'b0;
      msg_type_in   = '0;
      mac_out_in    = '0;
      addr_kind_in  = ADDR_NONE;
      addr_in       = '0;
      if (q_item.long_enough) begin
         sum_valid_in = 1'b1;
         dhcp_in      = cookie_in == COOKIE_VALUE;
         op_out_in    = op_in;
         mac_out_in   = mac_in;
         if (dhcp_in) begin
            type_found_in = type_in[8];
            msg_type_in   = type_in[7:0];
            if (req_ip_in[32]) begin
               addr_kind_in = ADDR_REQUESTED;
               addr_in      = req_ip_in[31:0];
            end else if (ciaddr_in != '0) begin
               addr_kind_in = ADDR_CLIENT;
               addr_in      = ciaddr_in;
            end else if (yiaddr_in != '0) begin
               addr_kind_in = ADDR_OFFERED;
               addr_in      = yiaddr_in;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || emit) begin
         phase_ff      <= PHASE_CODE;
         code_ff       <= '0;
         bytes_left_ff <= '0;
         stopped_ff    <= 1'b0;
         cookie_ff     <= '0;
         op_ff         <= '0;
         mac_ff        <= '0;
         ciaddr_ff     <= '0;
         yiaddr_ff     <= '0;
         type_ff       <= '0;
         req_ip_ff     <= '0;
         shift_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         code_ff       <= code_in;
         bytes_left_ff <= bytes_left_in;
         stopped_ff    <= stopped_in;
         cookie_ff     <= cookie_in;
         op_ff         <= op_in;
         mac_ff        <= mac_in;
         ciaddr_ff     <= ciaddr_in;
         yiaddr_ff     <= yiaddr_in;
         type_ff       <= type_in;
         req_ip_ff     <= req_ip_in;
         shift_ff      <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         sum_valid_ff  <= sum_valid_in;
         dhcp_ff       <= dhcp_in;
         op_out_ff     <= op_out_in;
         type_found_ff <= type_found_in;
         msg_type_ff   <= msg_type_in;
         mac_out_ff    <= mac_out_in;
         addr_kind_ff  <= addr_kind_in;
         addr_ff       <= addr_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_summary_valid = sum_valid_ff;
   assign rsp_is_dhcp       = dhcp_ff;
   assign rsp_op_code       = op_out_ff;
   assign rsp_type_found    = type_found_ff;
   assign rsp_message_type  = msg_type_ff;
   assign rsp_client_mac    = mac_out_ff;
   assign rsp_addr_kind     = addr_kind_ff;
   assign rsp_shown_address = addr_ff;

endmodule

// ----- hdl/dhcp_option_summary_parser.sv -----
// Top level of the DHCP/BOOTP option summary parser.
// Takes one payload byte per cycle while the queue has room and gives one summary
// transfer per packet, on its last byte. The front end classifies each byte by its
// position, a two-entry queue carries it to the back end, which captures header
// fields, walks the option TLVs and loads the summary into an output register. A
// summary is loaded into the output register when its last byte leaves the queue;
// bytes that produce no summary drain even while a summary waits, so input stalls
// only when a second packet end reaches the back end before the waiting summary is
// taken and the queue behind it fills.
module dhcp_option_summary_parser
   import dosp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_payload_byte,
   input  logic [15:0] req_payload_length,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_summary_valid,
   output logic        rsp_is_dhcp,
   output logic [7:0]  rsp_op_code,
   output logic        rsp_type_found,
   output logic [7:0]  rsp_message_type,
   output logic [47:0] rsp_client_mac,
   output logic [1:0]  rsp_addr_kind,
   output logic [31:0] rsp_shown_address
);

   item_type push_item;
   item_type pop_item;
   logic     push;
   logic     full;
   logic     pop;
   logic     pop_valid;

   dosp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_payload_byte   (req_payload_byte),
      .req_payload_length (req_payload_length),
      .req_last_byte      (req_last_byte),
      .q_full             (full),
      .q_push             (push),
      .q_item             (push_item)
   );

   dosp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   dosp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (pop_valid),
      .q_item            (pop_item),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_summary_valid (rsp_summary_valid),
      .rsp_is_dhcp       (rsp_is_dhcp),
      .rsp_op_code       (rsp_op_code),
      .rsp_type_found    (rsp_type_found),
      .rsp_message_type  (rsp_message_type),
      .rsp_client_mac    (rsp_client_mac),
      .rsp_addr_kind     (rsp_addr_kind),
      .rsp_shown_address (rsp_shown_address)
   );

endmodule

// ----- hdl/dosp_checker.sv -----
// Port-level checks for the DHCP option summary parser, bound to the top level.
module dosp_checker
   import dosp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_summary_valid,
   input logic        rsp_is_dhcp,
   input logic [7:0]  rsp_op_code,
   input logic        rsp_type_found,
   input logic [7:0]  rsp_message_type,
   input logic [47:0] rsp_client_mac,
   input logic [1:0]  rsp_addr_kind,
   input logic [31:0] rsp_shown_address
);

   // A waiting summary holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shown_address))
      else $error("summary dropped or changed while stalled");

   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_summary_valid |->
         !rsp_is_dhcp && rsp_op_code == 8'd0 && rsp_client_mac == 48'd0 &&
         rsp_addr_kind == ADDR_NONE)
      else $error("short packet summary carries data");

   a_bootp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_dhcp |->
         !rsp_type_found && rsp_message_type == 8'd0 &&
         rsp_addr_kind == ADDR_NONE && rsp_shown_address == 32'd0)
      else $error("plain BOOTP summary carries DHCP fields");

   a_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_addr_kind == ADDR_NONE |-> rsp_shown_address == 32'd0)
      else $error("address shown without an address kind");

   a_no_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_type_found |-> rsp_message_type == 8'd0)
      else $error("message type shown without a type option");

endmodule

bind dhcp_option_summary_parser dosp_checker u_dosp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_summary_valid (rsp_summary_valid),
   .rsp_is_dhcp       (rsp_is_dhcp),
   .rsp_op_code       (rsp_op_code),
   .rsp_type_found    (rsp_type_found),
   .rsp_message_type  (rsp_message_type),
   .rsp_client_mac    (rsp_client_mac),
   .rsp_addr_kind     (rsp_addr_kind),
   .rsp_shown_address (rsp_shown_address)
);
